/* rtl/tasfm_pkg.sv */
// shared types and constants for the three-axis sample fault monitor
package tasfm_pkg;

    // configuration port
    localparam int CFG_DATA_BITS = 23;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODE_SELECT      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWITCHOVER       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ABS_LIMIT        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_JUMP_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_FAIL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_FAIL_LIMIT  = 3'd5;

    // register widths
    localparam int MODE_BITS   = 2;
    localparam int LIMIT_BITS  = 23;
    localparam int FLIMIT_BITS = 8;

    // operating modes
    localparam logic [MODE_BITS-1:0] MODE_OTHER = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_11    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_33    = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_44    = 2'd3;

    // register reset values
    localparam logic [LIMIT_BITS-1:0]  ABS_LIMIT_RST        = 23'd655360;
    localparam logic [LIMIT_BITS-1:0]  JUMP_LIMIT_RST       = 23'd51275;
    localparam logic [FLIMIT_BITS-1:0] FRAME_FAIL_LIMIT_RST = 8'd20;
    localparam logic [FLIMIT_BITS-1:0] AXIS_FAIL_LIMIT_RST  = 8'd10;

    // status word layout
    localparam int NUM_AXES      = 3;
    localparam int INTER_BITS    = 7;
    localparam int OVERALL_BITS  = 12;
    localparam logic [OVERALL_BITS-1:0] PERM_X   = 12'h100;
    localparam logic [OVERALL_BITS-1:0] PERM_Y   = 12'h400;
    localparam logic [OVERALL_BITS-1:0] PERM_Z   = 12'h800;
    localparam logic [OVERALL_BITS-1:0] SECOND_X = 12'h020;
    localparam logic [OVERALL_BITS-1:0] SECOND_Y = 12'h040;
    localparam logic [OVERALL_BITS-1:0] SECOND_Z = 12'h080;

    // link flags in the input tuser, lowest bit first
    localparam int IN_USER_BITS = 4;

    // per-axis control from the top level
    typedef struct packed {
        logic update;
        logic frame_fail;
        logic mode_any;
        logic mark_en;
    } t_axis_ctrl;

    // per-axis results for this item
    typedef struct packed {
        logic mag;
        logic jump;
        logic subst;
        logic perm;
    } t_axis_status;

endpackage

/* rtl/tasfm_axis.sv */
// one axis: jump and magnitude checks, persistence counter and rollback
module tasfm_axis #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tasfm_pkg::t_axis_ctrl               i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic signed [SAMPLE_BITS-1:0]       i_prev,
    input  logic [tasfm_pkg::LIMIT_BITS-1:0]    i_abs_limit,
    input  logic [tasfm_pkg::LIMIT_BITS-1:0]    i_jump_limit,
    input  logic [tasfm_pkg::FLIMIT_BITS-1:0]   i_fail_limit,
    output logic signed [SAMPLE_BITS-1:0]       o_held,
    output tasfm_pkg::t_axis_status             o_status
);
    import tasfm_pkg::*;

    localparam int CW = ((SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS) + 2;
    localparam int KW = (COUNT_BITS > FLIMIT_BITS) ? COUNT_BITS : FLIMIT_BITS;

    logic                   r_mark;
    logic                   n_mark;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic [COUNT_BITS-1:0]  n_cnt;
    logic [COUNT_BITS-1:0]  cnt_inc;

    logic signed [SAMPLE_BITS-1:0] held0;
    logic signed [CW-1:0]  held_e;
    logic signed [CW-1:0]  prev_e;
    logic signed [CW-1:0]  lim_e;
    logic signed [CW-1:0]  jlim_e;
    logic signed [CW-1:0]  diff;
    logic signed [CW-1:0]  diff_abs;
    logic                  mag_hit;
    logic                  subst;
    logic                  cnt_below;
    logic                  inc_reached;

    // sample after a bad-frame rollback
    assign held0  = i_ctrl.frame_fail ? i_prev : i_sample;
    assign held_e = CW'(held0);
    assign prev_e = CW'(i_prev);
    assign lim_e  = $signed(CW'(i_abs_limit));
    assign jlim_e = $signed(CW'(i_jump_limit));

    // jump check on the magnitude of the step
    assign diff     = held_e - prev_e;
    assign diff_abs = diff[CW-1] ? -diff : diff;

    // magnitude check and persistence mark
    assign mag_hit = ((held_e > lim_e) || (held_e < -lim_e)) && i_ctrl.mode_any;
    assign n_mark  = mag_hit ? (i_ctrl.mark_en | r_mark) : 1'b0;
    assign subst   = n_mark && i_ctrl.mode_any && !i_ctrl.frame_fail;

    // saturating persistence counter
    assign cnt_inc     = (r_cnt == {COUNT_BITS{1'b1}}) ? r_cnt : r_cnt + COUNT_BITS'(1);
    assign inc_reached = KW'(cnt_inc) >= KW'(i_fail_limit);
    assign cnt_below   = KW'(r_cnt) < KW'(i_fail_limit);

    always_comb begin
        if (subst) begin
            n_cnt = cnt_inc;
        end else if (cnt_below) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt;
        end
    end

    assign o_held         = subst ? i_prev : held0;
    assign o_status.mag   = mag_hit;
    assign o_status.jump  = diff_abs > jlim_e;
    assign o_status.subst = subst;
    assign o_status.perm  = subst && inc_reached;

    // axis state advances once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.update) begin
            r_mark <= n_mark;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* rtl/three_axis_sample_fault_monitor.sv */
// top level of the three-axis sample fault monitor
// an accepted item passes the input register, then the result register, where a stall holds it
// throughput: one item per cycle unless the output stalls; counter and sticky-flag
// feedback closes in the single compare stage between the input and result registers
// reset: synchronous active low; clears counters, marks, sticky flags and
// valid bits, and loads the configuration registers with their defaults
module three_axis_sample_fault_monitor #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [tasfm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [tasfm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // input items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_x, sample_y, sample_z, prev_x, prev_y, prev_z
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // timeout, header_ok, checksum_ok, payload_ok
    input  logic [tasfm_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // held_x, held_y, held_z, frame_fail, substitution_flag, inter_status,
    // sticky status word, axis_failed, second_failed
    output logic [((3*SAMPLE_BITS+27+7)/8)*8-1:0] m_axis_tdata
);
    import tasfm_pkg::*;

    localparam int OUT_FIELD_W = 3*SAMPLE_BITS + 2 + INTER_BITS + OVERALL_BITS + 2*NUM_AXES;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int KW = (COUNT_BITS > FLIMIT_BITS) ? COUNT_BITS : FLIMIT_BITS;

    // configuration registers
    logic [MODE_BITS-1:0]   r_mode;
    logic                   r_switchover;
    logic [LIMIT_BITS-1:0]  r_abs_limit;
    logic [LIMIT_BITS-1:0]  r_jump_limit;
    logic [FLIMIT_BITS-1:0] r_frame_limit;
    logic [FLIMIT_BITS-1:0] r_axis_limit;

    // input register
    logic                          r_in_valid;
    logic [IN_USER_BITS-1:0]       r_in_flags;
    logic signed [SAMPLE_BITS-1:0] r_in_sample [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_in_prev   [NUM_AXES];

    // block state
    logic [COUNT_BITS-1:0]   r_frame_cnt;
    logic [COUNT_BITS-1:0]   n_frame_cnt;
    logic [COUNT_BITS-1:0]   frame_inc;
    logic                    r_subst;
    logic                    n_subst;
    logic [OVERALL_BITS-1:0] r_overall;
    logic [OVERALL_BITS-1:0] n_overall;
    logic [NUM_AXES-1:0]     r_axis_failed;
    logic [NUM_AXES-1:0]     n_axis_failed;
    logic [NUM_AXES-1:0]     r_second_failed;
    logic [NUM_AXES-1:0]     n_second_failed;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic advance;
    logic update;
    logic mode_1144;
    logic mode_any;
    logic link_bad;
    logic frame_fail;
    logic all_fail;

    logic signed [SAMPLE_BITS-1:0] held [NUM_AXES];
    t_axis_ctrl                    axis_ctrl [NUM_AXES];
    t_axis_status                  axis_stat [NUM_AXES];
    logic [INTER_BITS-1:0]         inter;
    logic [OVERALL_BITS-1:0]       perm_bits;
    logic [NUM_AXES-1:0]           perm_vec;

    // handshake: the result register drains, the input register follows
    assign advance       = !r_out_valid || m_axis_tready;
    assign update        = advance && r_in_valid;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OTHER;
            r_switchover  <= 1'b0;
            r_abs_limit   <= ABS_LIMIT_RST;
            r_jump_limit  <= JUMP_LIMIT_RST;
            r_frame_limit <= FRAME_FAIL_LIMIT_RST;
            r_axis_limit  <= AXIS_FAIL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE_SELECT:      r_mode        <= i_cfg_data[MODE_BITS-1:0];
                REG_SWITCHOVER:       r_switchover  <= i_cfg_data[0];
                REG_ABS_LIMIT:        r_abs_limit   <= i_cfg_data[LIMIT_BITS-1:0];
                REG_JUMP_LIMIT:       r_jump_limit  <= i_cfg_data[LIMIT_BITS-1:0];
                REG_FRAME_FAIL_LIMIT: r_frame_limit <= i_cfg_data[FLIMIT_BITS-1:0];
                REG_AXIS_FAIL_LIMIT:  r_axis_limit  <= i_cfg_data[FLIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_flags <= s_axis_tuser;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_in_sample[i] <= s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                r_in_prev[i]   <= s_axis_tdata[(i+NUM_AXES)*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // frame check
    assign mode_1144  = (r_mode == MODE_11) || (r_mode == MODE_44);
    assign mode_any   = r_mode != MODE_OTHER;
    assign link_bad   = r_in_flags[0] || !r_in_flags[1] || !r_in_flags[2] || !r_in_flags[3];
    assign frame_fail = link_bad && mode_1144;

    // saturating bad-frame counter
    assign frame_inc = (r_frame_cnt == {COUNT_BITS{1'b1}}) ?
                       r_frame_cnt : r_frame_cnt + COUNT_BITS'(1);
    assign all_fail  = frame_fail && (KW'(frame_inc) >= KW'(r_frame_limit));

    always_comb begin
        if (frame_fail) begin
            n_frame_cnt = frame_inc;
        end else if (KW'(r_frame_cnt) < KW'(r_frame_limit)) begin
            n_frame_cnt = '0;
        end else begin
            n_frame_cnt = r_frame_cnt;
        end
    end

    // per-axis checks
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        assign axis_ctrl[g].update     = update;
        assign axis_ctrl[g].frame_fail = frame_fail;
        assign axis_ctrl[g].mode_any   = mode_any;
        assign axis_ctrl[g].mark_en    = (g != 0) || !r_switchover;
        assign perm_vec[g]             = axis_stat[g].perm;

        tasfm_axis #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COUNT_BITS  (COUNT_BITS)
        ) u_axis (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (axis_ctrl[g]),
            .i_sample     (r_in_sample[g]),
            .i_prev       (r_in_prev[g]),
            .i_abs_limit  (r_abs_limit),
            .i_jump_limit (r_jump_limit),
            .i_fail_limit (r_axis_limit),
            .o_held       (held[g]),
            .o_status     (axis_stat[g])
        );
    end

    // status words and sticky flags
    assign inter = {axis_stat[2].jump, axis_stat[1].jump, axis_stat[0].jump, 1'b0,
                    axis_stat[2].mag, axis_stat[1].mag, axis_stat[0].mag};

    assign perm_bits = (perm_vec[0] ? PERM_X : '0) | (perm_vec[1] ? PERM_Y : '0)
                     | (perm_vec[2] ? PERM_Z : '0);

    always_comb begin
        n_subst         = r_subst | frame_fail | axis_stat[0].subst
                        | axis_stat[1].subst | axis_stat[2].subst;
        n_overall       = r_overall | perm_bits;
        n_axis_failed   = r_axis_failed | perm_vec;
        n_second_failed = r_second_failed;
        if (all_fail) begin
            n_overall       = n_overall | PERM_X | PERM_Y | PERM_Z
                            | SECOND_X | SECOND_Y | SECOND_Z;
            n_axis_failed   = {NUM_AXES{1'b1}};
            n_second_failed = {NUM_AXES{1'b1}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt     <= '0;
            r_subst         <= 1'b0;
            r_overall       <= '0;
            r_axis_failed   <= '0;
            r_second_failed <= '0;
        end else if (update) begin
            r_frame_cnt     <= n_frame_cnt;
            r_subst         <= n_subst;
            r_overall       <= n_overall;
            r_axis_failed   <= n_axis_failed;
            r_second_failed <= n_second_failed;
        end
    end

    // result packing
    assign n_out_data = OUT_DATA_W'({n_second_failed, n_axis_failed, n_overall, inter,
                                     n_subst, frame_fail, held[2], held[1], held[0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (update) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
